/* hw/rtl/dpa_pkg.sv */
package dpa_pkg;

  // Default counter width of the debounce counters
  localparam int COUNT_WIDTH_DEF = 8;

  // Threshold register width and reset values
  localparam int THR_W = 8;
  localparam logic [THR_W-1:0] LEVEL_DEB_RST  = 8'd50;
  localparam logic [THR_W-1:0] MODE_DEB_RST   = 8'd10;
  localparam logic [THR_W-1:0] ENABLE_DEB_RST = 8'd10;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_DEB  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE_DEB   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_DEB = 2'd2;

  // Debounce counter slots
  localparam int NUM_CNT       = 10;
  localparam int CNT_MODE_MAN  = 0;
  localparam int CNT_MODE_AUTO = 1;
  localparam int CNT_EN_ON     = 2;  // + 2*pump
  localparam int CNT_EN_OFF    = 3;  // + 2*pump
  localparam int CNT_LVL_FULL  = 6;  // + 2*tank
  localparam int CNT_LVL_EMPTY = 7;  // + 2*tank

  // Input item bit positions
  localparam int IN_MODE  = 0;
  localparam int IN_UPPER = 1;
  localparam int IN_LOWER = 2;
  localparam int IN_EN1   = 3;
  localparam int IN_EN2   = 4;

  // Result item bit positions
  localparam int OUT_P1_DRIVE  = 0;
  localparam int OUT_P2_DRIVE  = 1;
  localparam int OUT_AUTO_LED  = 2;
  localparam int OUT_WATER_LED = 3;
  localparam int OUT_P1_LED    = 4;
  localparam int OUT_P2_LED    = 5;
  localparam int OUT_HEARTBEAT = 6;

  // Pump on duty
  typedef enum logic [1:0] {
    DUTY_P1   = 2'd0,
    DUTY_P2   = 2'd1,
    DUTY_NONE = 2'd2
  } duty_t;

  // Duty selector after a stop: hand over to the other enabled pump
  function automatic duty_t stop_duty(input duty_t duty, input logic [1:0] en);
    duty_t d;
    d = (duty == DUTY_P1) ? DUTY_P2 : DUTY_P1;
    if (d == DUTY_P1 && !en[0]) d = DUTY_P2;
    if (d == DUTY_P2 && !en[1]) d = DUTY_P1;
    if (!en[0] && !en[1]) d = DUTY_NONE;
    return d;
  endfunction

endpackage

/* hw/rtl/duplex_pump_alternator.sv */
// Duplex pump alternator: two pumps take turns filling an upper tank from a
// lower tank.
// Input channel in_*: one control tick per item, five active-low raw pins.
// Result channel out_*: one item per tick with pump drives, four LEDs and
// the heartbeat.
// Config channel cfg_*: debounce thresholds, always ready; index 0 level,
// 1 mode, 2 enable; index 3 is ignored. Write only while the block is idle.
// Latency: the result of a tick is valid on the cycle after it is accepted.
// Throughput: one tick per cycle unless results stall; all debounce
// counters, flags and pump control update in one registered pass per tick.
// When the receiver stalls, the result stays in the output register and
// in_tready drops until it is taken; a new tick is accepted in the same
// cycle the pending result leaves.
// Reset (rst_n low, synchronous): manual mode, both pumps disabled and
// stopped, no pump on duty, tanks read empty, counters cleared, thresholds
// back to 50/10/10, output empty. The first tick always latches the drives.
module duplex_pump_alternator
  import dpa_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // tick input
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // [0] mode_switch_pin, [1] upper_level_pin, [2] lower_level_pin,
  // [3] pump1_enable_pin, [4] pump2_enable_pin, [7:5] zero
  input  logic [7:0]           in_tdata,
  // result output
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // [0] pump1_drive, [1] pump2_drive, [2] auto_led, [3] water_led,
  // [4] pump1_led, [5] pump2_led, [6] heartbeat_led, [7] zero
  output logic [7:0]           out_tdata,
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [THR_W-1:0]     cfg_data
);

  localparam int CMP_W = (COUNT_WIDTH > THR_W) ? COUNT_WIDTH : THR_W;

  typedef logic [COUNT_WIDTH-1:0] cnt_t;

  // Thresholds
  logic [THR_W-1:0] level_thr_r, mode_thr_r, enable_thr_r;

  // Controller state
  cnt_t        cnt_r [NUM_CNT];
  cnt_t        cnt_nxt [NUM_CNT];
  logic        auto_r, auto_nxt;
  logic [1:0]  en_r, en_nxt;
  logic [1:0]  run_r, run_nxt;
  logic [1:0]  full_r, full_nxt;
  duty_t       duty_r, duty_nxt;
  logic        lvl_ch_r, lvl_ch_nxt;
  logic        sw_ch_r, sw_ch_nxt;
  logic [5:0]  img_r, img_nxt;
  logic        hb_r, hb_nxt;
  logic        out_tvalid_r;

  logic        in_acc;
  logic [1:0]  lvl_pin, en_pin;

  function automatic logic over_thr(input cnt_t c, input logic [THR_W-1:0] thr);
    logic [CMP_W-1:0] ce, te;
    ce = CMP_W'(c);
    te = CMP_W'(thr);
    return ce > te;
  endfunction

  assign cfg_ready  = 1'b1;
  assign in_tready  = !out_tvalid_r || out_tready;
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {1'b0, hb_r, img_r};

  assign lvl_pin = {in_tdata[IN_LOWER], in_tdata[IN_UPPER]};
  assign en_pin  = {in_tdata[IN_EN2], in_tdata[IN_EN1]};

  // One tick of the controller
  always_comb begin
    cnt_t inc;
    inc        = '0;
    cnt_nxt    = cnt_r;
    auto_nxt   = auto_r;
    en_nxt     = en_r;
    run_nxt    = run_r;
    full_nxt   = full_r;
    duty_nxt   = duty_r;
    lvl_ch_nxt = lvl_ch_r;
    sw_ch_nxt  = sw_ch_r;
    img_nxt    = img_r;
    hb_nxt     = !hb_r;

    // mode switch debounce
    if (!in_tdata[IN_MODE]) begin
      if (auto_r) begin
        cnt_nxt[CNT_MODE_AUTO] = '0;
        inc = cnt_r[CNT_MODE_MAN] + 1'b1;
        if (over_thr(inc, mode_thr_r)) begin
          auto_nxt = 1'b0;
          cnt_nxt[CNT_MODE_MAN] = '0;
        end else begin
          cnt_nxt[CNT_MODE_MAN] = inc;
        end
      end
    end else if (!auto_r) begin
      cnt_nxt[CNT_MODE_MAN] = '0;
      inc = cnt_r[CNT_MODE_AUTO] + 1'b1;
      if (over_thr(inc, mode_thr_r)) begin
        auto_nxt = 1'b1;
        cnt_nxt[CNT_MODE_AUTO] = '0;
      end else begin
        cnt_nxt[CNT_MODE_AUTO] = inc;
      end
    end

    // pump enable debounce; disabling a pump hands duty to the other
    for (int k = 0; k < 2; k++) begin
      if (!en_pin[k]) begin
        if (en_r[k]) begin
          cnt_nxt[CNT_EN_ON + 2*k] = '0;
          inc = cnt_r[CNT_EN_OFF + 2*k] + 1'b1;
          if (over_thr(inc, enable_thr_r)) begin
            en_nxt[k] = 1'b0;
            duty_nxt = (k == 0) ? DUTY_P2 : DUTY_P1;
            cnt_nxt[CNT_EN_OFF + 2*k] = '0;
          end else begin
            cnt_nxt[CNT_EN_OFF + 2*k] = inc;
          end
        end
      end else if (!en_r[k]) begin
        cnt_nxt[CNT_EN_OFF + 2*k] = '0;
        inc = cnt_r[CNT_EN_ON + 2*k] + 1'b1;
        if (over_thr(inc, enable_thr_r)) begin
          en_nxt[k] = 1'b1;
          cnt_nxt[CNT_EN_ON + 2*k] = '0;
        end else begin
          cnt_nxt[CNT_EN_ON + 2*k] = inc;
        end
      end
    end

    // both out of service: stop, nobody on duty
    if (en_nxt == 2'b00) begin
      run_nxt  = 2'b00;
      duty_nxt = DUTY_NONE;
    end
    if (auto_nxt != auto_r || en_nxt != en_r) sw_ch_nxt = 1'b1;
    if (auto_nxt != auto_r) begin
      run_nxt  = 2'b00;
      duty_nxt = stop_duty(duty_nxt, en_nxt);
    end

    // level sensor debounce (tank 0 upper, tank 1 lower)
    for (int k = 0; k < 2; k++) begin
      if (!lvl_pin[k]) begin
        inc = cnt_r[CNT_LVL_FULL + 2*k] + 1'b1;
        if (over_thr(inc, level_thr_r)) begin
          if (!full_r[k]) begin
            full_nxt[k] = 1'b1;
            cnt_nxt[CNT_LVL_EMPTY + 2*k] = '0;
            lvl_ch_nxt = 1'b1;
          end
          cnt_nxt[CNT_LVL_FULL + 2*k] = '0;
        end else begin
          cnt_nxt[CNT_LVL_FULL + 2*k] = inc;
        end
      end else begin
        inc = cnt_r[CNT_LVL_EMPTY + 2*k] + 1'b1;
        if (over_thr(inc, level_thr_r)) begin
          if (full_r[k]) begin
            full_nxt[k] = 1'b0;
            cnt_nxt[CNT_LVL_FULL + 2*k] = '0;
            lvl_ch_nxt = 1'b1;
          end
          cnt_nxt[CNT_LVL_EMPTY + 2*k] = '0;
        end else begin
          cnt_nxt[CNT_LVL_EMPTY + 2*k] = inc;
        end
      end
    end

    // pump control
    if ((auto_nxt && lvl_ch_nxt && full_nxt[1] && !full_nxt[0]) ||
        (!auto_nxt && full_nxt[1] && (en_nxt[0] != en_nxt[1]))) begin
      case (duty_nxt)
        DUTY_P1: run_nxt = 2'b01;
        DUTY_P2: run_nxt = 2'b10;
        default: ;
      endcase
    end else if (!auto_nxt || lvl_ch_nxt) begin
      run_nxt  = 2'b00;
      duty_nxt = stop_duty(duty_nxt, en_nxt);
    end

    // drives latch only on a change
    if (lvl_ch_nxt || sw_ch_nxt) begin
      img_nxt[OUT_P2_DRIVE:OUT_P1_DRIVE] = run_nxt;
      lvl_ch_nxt = 1'b0;
      sw_ch_nxt  = 1'b0;
    end

    // indicators
    img_nxt[OUT_AUTO_LED] = auto_nxt;
    for (int k = 0; k < 2; k++) begin
      if (!en_nxt[k])      img_nxt[OUT_P1_LED + k] = 1'b0;
      else if (run_nxt[k]) img_nxt[OUT_P1_LED + k] = 1'b1;
      else                 img_nxt[OUT_P1_LED + k] = !img_r[OUT_P1_LED + k];
    end
    if (full_nxt == 2'b11)      img_nxt[OUT_WATER_LED] = 1'b0;
    else if (full_nxt == 2'b10) img_nxt[OUT_WATER_LED] = 1'b1;
    else                        img_nxt[OUT_WATER_LED] = !img_r[OUT_WATER_LED];
  end

  // State, configuration and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_thr_r  <= LEVEL_DEB_RST;
      mode_thr_r   <= MODE_DEB_RST;
      enable_thr_r <= ENABLE_DEB_RST;
      for (int i = 0; i < NUM_CNT; i++) cnt_r[i] <= '0;
      auto_r       <= 1'b0;
      en_r         <= 2'b00;
      run_r        <= 2'b00;
      full_r       <= 2'b00;
      duty_r       <= DUTY_NONE;
      lvl_ch_r     <= 1'b1;
      sw_ch_r      <= 1'b1;
      img_r        <= '0;
      hb_r         <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_LEVEL_DEB:  level_thr_r  <= cfg_data;
          CFG_MODE_DEB:   mode_thr_r   <= cfg_data;
          CFG_ENABLE_DEB: enable_thr_r <= cfg_data;
          default: ;
        endcase
      end
      if (in_acc) begin
        cnt_r    <= cnt_nxt;
        auto_r   <= auto_nxt;
        en_r     <= en_nxt;
        run_r    <= run_nxt;
        full_r   <= full_nxt;
        duty_r   <= duty_nxt;
        lvl_ch_r <= lvl_ch_nxt;
        sw_ch_r  <= sw_ch_nxt;
        img_r    <= img_nxt;
        hb_r     <= hb_nxt;
      end
      if (in_acc)          out_tvalid_r <= 1'b1;
      else if (out_tready) out_tvalid_r <= 1'b0;
    end
  end

endmodule

/* hw/rtl/dpa_checker.sv */
module dpa_checker
  import dpa_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_tvalid,
  input logic                 in_tready,
  input logic                 out_tvalid,
  input logic                 out_tready,
  input logic [7:0]           out_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // an empty output never blocks the input
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input blocked with empty output");

  // each accepted tick flips the heartbeat in the next result
  a_heartbeat: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=>
      out_tvalid && (out_tdata[OUT_HEARTBEAT] != $past(out_tdata[OUT_HEARTBEAT])))
    else $error("heartbeat did not toggle");

  // the two pumps never run together
  a_one_pump: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[OUT_P1_DRIVE] && out_tdata[OUT_P2_DRIVE]))
    else $error("both pumps driven");

endmodule

bind duplex_pump_alternator dpa_checker u_dpa_checker (.*);

/* verif/pump_tick_checker.sv */
// Watches the tick, result and threshold channels of the pump alternator,
// predicts every result item and compares it with what the block returns.
module pump_tick_checker
  import dpa_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic                 in_tready,
  input  logic [7:0]           in_tdata,
  input  logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic [7:0]           out_tdata,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [THR_W-1:0]     cfg_data,
  output int                   mismatch_count,
  output int                   results_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  // Thresholds
  logic [THR_W-1:0] thr_level;
  logic [THR_W-1:0] thr_mode;
  logic [THR_W-1:0] thr_enable;

  // Controller state
  logic                   auto_mode;
  logic [1:0]             pump_en;
  logic [1:0]             pump_run;
  logic [1:0]             tank_full;   // [0] upper, [1] lower
  duty_t                  duty;
  logic [COUNT_WIDTH-1:0] deb_cnt [NUM_CNT];
  logic                   level_chg;
  logic                   switch_chg;
  logic [5:0]             port_img;
  logic                   beat;

  logic [7:0] pending_results [$];
  int         errors = 0;

  // Bump a debounce counter; true once it passes the threshold
  function automatic logic count_past(input int slot, input logic [THR_W-1:0] thr);
    deb_cnt[slot] = deb_cnt[slot] + 1'b1;
    return deb_cnt[slot] > thr;
  endfunction

  // Stop both pumps and hand the duty to the other enabled pump
  task automatic stop_and_rotate();
    pump_run = 2'b00;
    duty = (duty == DUTY_P1) ? DUTY_P2 : DUTY_P1;
    if (duty == DUTY_P1 && !pump_en[0]) duty = DUTY_P2;
    if (duty == DUTY_P2 && !pump_en[1]) duty = DUTY_P1;
    if (!pump_en[0] && !pump_en[1]) duty = DUTY_NONE;
  endtask

  // Run the pump on duty; no pump on duty leaves the flags alone
  task automatic run_on_duty();
    if (duty == DUTY_P1) pump_run = 2'b01;
    else if (duty == DUTY_P2) pump_run = 2'b10;
  endtask

  function automatic string field_name(input int b);
    case (b)
      OUT_P1_DRIVE:  return "pump1_drive";
      OUT_P2_DRIVE:  return "pump2_drive";
      OUT_AUTO_LED:  return "auto_led";
      OUT_WATER_LED: return "water_led";
      OUT_P1_LED:    return "pump1_led";
      OUT_P2_LED:    return "pump2_led";
      OUT_HEARTBEAT: return "heartbeat_led";
      default:       return "tdata pad";
    endcase
  endfunction

  // One control tick: debounce, pump control, latch and indicators
  task automatic advance_controller(input logic [7:0] pins, output logic [7:0] res);
    logic       mode_pin;
    logic [1:0] lvl_pin;
    logic [1:0] en_pin;
    logic       prev_mode;
    logic [1:0] prev_en;
    mode_pin  = pins[IN_MODE];
    lvl_pin   = {pins[IN_LOWER], pins[IN_UPPER]};
    en_pin    = {pins[IN_EN2], pins[IN_EN1]};
    prev_mode = auto_mode;
    prev_en   = pump_en;

    // mode switch: count only toward the other mode
    if (!mode_pin) begin
      if (auto_mode) begin
        deb_cnt[CNT_MODE_AUTO] = '0;
        if (count_past(CNT_MODE_MAN, thr_mode)) begin
          auto_mode = 1'b0;
          deb_cnt[CNT_MODE_MAN] = '0;
        end
      end
    end else if (!auto_mode) begin
      deb_cnt[CNT_MODE_MAN] = '0;
      if (count_past(CNT_MODE_AUTO, thr_mode)) begin
        auto_mode = 1'b1;
        deb_cnt[CNT_MODE_AUTO] = '0;
      end
    end

    // enable switches; losing a pump passes duty to the other one
    for (int k = 0; k < 2; k++) begin
      if (!en_pin[k]) begin
        if (pump_en[k]) begin
          deb_cnt[CNT_EN_ON + 2*k] = '0;
          if (count_past(CNT_EN_OFF + 2*k, thr_enable)) begin
            pump_en[k] = 1'b0;
            duty = (k == 0) ? DUTY_P2 : DUTY_P1;
            deb_cnt[CNT_EN_OFF + 2*k] = '0;
          end
        end
      end else if (!pump_en[k]) begin
        deb_cnt[CNT_EN_OFF + 2*k] = '0;
        if (count_past(CNT_EN_ON + 2*k, thr_enable)) begin
          pump_en[k] = 1'b1;
          deb_cnt[CNT_EN_ON + 2*k] = '0;
        end
      end
    end

    if (pump_en == 2'b00) begin
      duty = DUTY_NONE;
      stop_and_rotate();
    end
    if (prev_mode != auto_mode || prev_en != pump_en) switch_chg = 1'b1;
    if (prev_mode != auto_mode) stop_and_rotate();

    // level sensors count both ways
    for (int k = 0; k < 2; k++) begin
      if (!lvl_pin[k]) begin
        if (count_past(CNT_LVL_FULL + 2*k, thr_level)) begin
          if (!tank_full[k]) begin
            tank_full[k] = 1'b1;
            deb_cnt[CNT_LVL_EMPTY + 2*k] = '0;
            level_chg = 1'b1;
          end
          deb_cnt[CNT_LVL_FULL + 2*k] = '0;
        end
      end else begin
        if (count_past(CNT_LVL_EMPTY + 2*k, thr_level)) begin
          if (tank_full[k]) begin
            tank_full[k] = 1'b0;
            deb_cnt[CNT_LVL_FULL + 2*k] = '0;
            level_chg = 1'b1;
          end
          deb_cnt[CNT_LVL_EMPTY + 2*k] = '0;
        end
      end
    end

    // pump control
    if (auto_mode) begin
      if (level_chg) begin
        if (tank_full[1] && !tank_full[0]) run_on_duty();
        else stop_and_rotate();
      end
    end else if (!tank_full[1] || pump_en[0] == pump_en[1]) begin
      stop_and_rotate();
    end else begin
      run_on_duty();
    end

    // drives latch only on a change
    if (level_chg || switch_chg) begin
      port_img[1:0] = pump_run;
      level_chg  = 1'b0;
      switch_chg = 1'b0;
    end

    port_img[2] = auto_mode;
    for (int k = 0; k < 2; k++) begin
      if (!pump_en[k]) port_img[4+k] = 1'b0;
      else if (pump_run[k]) port_img[4+k] = 1'b1;
      else port_img[4+k] = ~port_img[4+k];
    end
    if (tank_full[0] && tank_full[1]) port_img[3] = 1'b0;
    else if (!tank_full[0] && tank_full[1]) port_img[3] = 1'b1;
    else if (!tank_full[1]) port_img[3] = ~port_img[3];

    beat = ~beat;

    res = '0;
    res[OUT_P1_DRIVE]  = port_img[0];
    res[OUT_P2_DRIVE]  = port_img[1];
    res[OUT_AUTO_LED]  = port_img[2];
    res[OUT_WATER_LED] = port_img[3];
    res[OUT_P1_LED]    = port_img[4];
    res[OUT_P2_LED]    = port_img[5];
    res[OUT_HEARTBEAT] = beat;
  endtask

  always @(posedge clk) begin
    logic [7:0] want;
    if (!rst_n) begin
      thr_level  = LEVEL_DEB_RST;
      thr_mode   = MODE_DEB_RST;
      thr_enable = ENABLE_DEB_RST;
      auto_mode  = 1'b0;
      pump_en    = 2'b00;
      pump_run   = 2'b00;
      tank_full  = 2'b00;
      duty       = DUTY_NONE;
      for (int i = 0; i < NUM_CNT; i++) deb_cnt[i] = '0;
      level_chg  = 1'b1;
      switch_chg = 1'b1;
      port_img   = '0;
      beat       = 1'b0;
      pending_results.delete();
    end else begin
      // returned result against the oldest prediction
      if (out_tvalid && out_tready) begin
        if (pending_results.size() == 0) begin
          $error("result item %02h with no tick outstanding", out_tdata);
          errors++;
        end else begin
          want = pending_results.pop_front();
          for (int b = 0; b < 8; b++) begin
            if (want[b] !== out_tdata[b]) begin
              $error("%s: expected %0d, actual %0d", field_name(b), want[b], out_tdata[b]);
              errors++;
            end
          end
        end
      end

      // a tick taken at this edge still sees the old thresholds
      if (in_tvalid && in_tready) begin
        advance_controller(in_tdata, want);
        pending_results.push_back(want);
      end

      // threshold writes; the spare index is ignored
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_LEVEL_DEB:  thr_level  = cfg_data;
          CFG_MODE_DEB:   thr_mode   = cfg_data;
          CFG_ENABLE_DEB: thr_enable = cfg_data;
          default: ;
        endcase
      end
    end
    mismatch_count <= errors;
    results_owed   <= pending_results.size();
  end

endmodule

/* verif/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import dpa_pkg::*;

  localparam int RESET_CYCLES   = 9;
  localparam int LONG_HOLD      = 200;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 4;
  localparam int NUM_PHASES     = 7;
  localparam int NUM_DIRECTED   = 18;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  // [0] mode_switch_pin, [1] upper_level_pin, [2] lower_level_pin,
  // [3] pump1_enable_pin, [4] pump2_enable_pin, [7:5] zero
  logic [7:0]           in_tdata   = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  // [0] pump1_drive, [1] pump2_drive, [2] auto_led, [3] water_led,
  // [4] pump1_led, [5] pump2_led, [6] heartbeat_led, [7] zero
  logic [7:0]           out_tdata;
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [THR_W-1:0]     cfg_data   = '0;

  int mismatch_count;
  int results_owed;

  // stimulus knobs seen by the receiver, and the idle count of the watchdog
  logic stall_phase = 1'b0;
  logic quiet_tail  = 1'b0;
  logic hold_taken  = 1'b0;
  int   idle_cycles = 0;

  // random walk of the pins
  logic [4:0] steady    = '0;
  int         hold_left = 0;

  // per phase: thresholds, item count and how long pins stay put
  int ph_level [NUM_PHASES] = '{0, 2, 50, 7, 254, 255, 1};
  int ph_mode  [NUM_PHASES] = '{0, 1, 10, 3, 254, 255, 0};
  int ph_en    [NUM_PHASES] = '{0, 3, 10, 0, 254, 255, 2};
  int ph_items [NUM_PHASES] = '{110, 110, 160, 110, 280, 60, 120};
  int ph_span  [NUM_PHASES] = '{4, 8, 60, 16, 270, 20, 6};

  // pins {en2, en1, lower, upper, mode}, all active low
  logic [4:0] directed_pins [NUM_DIRECTED] = '{
    5'b11110, 5'b11010, 5'b11010, 5'b01010, 5'b01011, 5'b11011,
    5'b11011, 5'b11001, 5'b11001, 5'b11011, 5'b11011, 5'b10011,
    5'b00011, 5'b11011, 5'b11111, 5'b11111, 5'b11110, 5'b00000
  };

  duplex_pump_alternator uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  pump_tick_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .results_owed   (results_owed)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // receiver: one long hold-off in the pressure phase, always ready in the quiet tail, short bursts otherwise
  always begin
    @(posedge clk);
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (quiet_tail) begin
      out_tready <= 1'b1;
    end else if (stall_phase && !hold_taken) begin
      out_tready <= 1'b0;
      hold_taken <= 1'b1;
      repeat (LONG_HOLD) @(posedge clk);
    end else if ($urandom_range(0, 3) == 0) begin
      out_tready <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // watchdog on cycles with no item moving
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // offer one tick, with an optional gap in front
  task automatic send_tick(input logic [4:0] pins);
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, pins};
    do @(posedge clk); while (!in_tready);
  endtask

  // stop offering and wait until every result has come back
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [THR_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic program_thresholds(input logic [THR_W-1:0] lvl, input logic [THR_W-1:0] mode,
                                    input logic [THR_W-1:0] en);
    write_reg(CFG_LEVEL_DEB, lvl);
    write_reg(CFG_MODE_DEB, mode);
    write_reg(CFG_ENABLE_DEB, en);
    write_reg(CFG_SPARE, THR_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // pins mostly hold long enough to debounce, with glitches and noise
  task automatic next_pins(input int span, output logic [4:0] pins);
    int b;
    if (hold_left == 0) begin
      b = $urandom_range(0, 4);
      steady[b] = ~steady[b];
      hold_left = $urandom_range(0, span);
    end else begin
      hold_left--;
    end
    pins = steady;
    if ($urandom_range(0, 15) == 0) begin
      pins = 5'($urandom);
    end else if ($urandom_range(0, 7) == 0) begin
      b = $urandom_range(0, 4);
      pins[b] = ~pins[b];
    end
  endtask

  initial begin
    logic [4:0] pins;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // reset thresholds, first tick latches the drives
    send_tick(5'b00000);
    send_tick(5'b11111);
    send_tick(5'b11111);
    drain();

    // fast thresholds for the directed walk through the pump control
    program_thresholds(8'd1, 8'd0, 8'd0);
    for (int i = 0; i < NUM_DIRECTED; i++) send_tick(directed_pins[i]);

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      program_thresholds(THR_W'(ph_level[p]), THR_W'(ph_mode[p]), THR_W'(ph_en[p]));
      stall_phase <= (p == 2);
      quiet_tail  <= (p == NUM_PHASES - 1);
      hold_left = 0;
      for (int n = 0; n < ph_items[p]; n++) begin
        next_pins(ph_span[p], pins);
        send_tick(pins);
      end
    end
    drain();

    if (mismatch_count == 0 && results_owed == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
